/* hdl/direct_mapped_writeback_cache_defines.svh */
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define DMWC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dmwc check failed");

// Clocked assertion that also holds during reset.
`define DMWC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dmwc check failed during or after reset");

`endif

/* hdl/dmwc_pkg.sv */
package dmwc_pkg;

  localparam int ADDR_FIELD_W = 16;
  localparam int BYTE_W       = 8;

  localparam int DEF_LINE_COUNT   = 32;
  localparam int DEF_LINE_BYTES   = 16;
  localparam int DEF_ADDRESS_BITS = 16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [ADDR_FIELD_W-1:0] address;
    logic [BYTE_W-1:0]       write_data;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              line_was_dirty;
    logic              hit;
  } rsp_t;

endpackage

/* hdl/dmwc_ram.sv */
module dmwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/direct_mapped_writeback_cache.sv */
// Channel | Signals                      | Item
// req     | req_valid, req_ready, req    | mode, address, write_data
// rsp     | rsp_valid, rsp_ready, rsp    | read_data, line_was_dirty, hit (reads only)
//
// A hit is resolved in the LOOK state after acceptance; a read result then waits in the output register.
// A miss on a clean line fills the line from the backing memory (FILL); a read miss then passes through DONE.
// A miss on a dirty line first writes the old line back over the byte-wide port (WB).
// After reset the backing memory is swept to zero with req_ready low.
// A read result that finds rsp still occupied holds the block until rsp_ready frees it.
module direct_mapped_writeback_cache #(
  parameter int LINE_COUNT   = dmwc_pkg::DEF_LINE_COUNT,
  parameter int LINE_BYTES   = dmwc_pkg::DEF_LINE_BYTES,
  parameter int ADDRESS_BITS = dmwc_pkg::DEF_ADDRESS_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dmwc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dmwc_pkg::rsp_t rsp
);

  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int IDX_W      = $clog2(LINE_COUNT);
  localparam int AW         = ADDRESS_BITS;
  localparam int TAG_W      = AW - OFF_W - IDX_W;
  localparam int DA_W       = IDX_W + OFF_W;
  localparam int DATA_DEPTH = LINE_COUNT * LINE_BYTES;
  localparam int BACK_DEPTH = 2 ** AW;
  localparam int BW         = dmwc_pkg::BYTE_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]            state;
  logic [AW-1:0]         clr_addr;
  logic                  mode_r;
  logic [OFF_W-1:0]      off_r;
  logic [IDX_W-1:0]      idx_r;
  logic [TAG_W-1:0]      tag_r;
  logic [BW-1:0]         wdata_r;
  logic [TAG_W-1:0]      old_tag;
  logic [OFF_W:0]        cnt;
  logic                  rd_valid;
  logic [OFF_W-1:0]      rd_off;
  logic [BW-1:0]         res_data;
  logic                  res_dirty;
  logic                  res_hit;
  logic [LINE_COUNT-1:0] valid_bits;
  logic [LINE_COUNT-1:0] dirty_bits;

  logic [AW-1:0]         addr_in;
  logic [OFF_W-1:0]      in_off;
  logic [IDX_W-1:0]      in_idx;
  logic [TAG_W-1:0]      in_tag;
  logic                  accept;
  logic                  look_hit;
  logic                  slot_free;
  logic                  fill_last;
  logic                  push;
  dmwc_pkg::rsp_t        push_item;

  logic                  data_we;
  logic [DA_W-1:0]       data_waddr;
  logic [BW-1:0]         data_wdata;
  logic [DA_W-1:0]       data_raddr;
  logic [BW-1:0]         data_rdata;
  logic                  back_we;
  logic [AW-1:0]         back_waddr;
  logic [BW-1:0]         back_wdata;
  logic [AW-1:0]         back_raddr;
  logic [BW-1:0]         back_rdata;
  logic [TAG_W-1:0]      tag_rdata;

  assign addr_in   = AW'(req.address);
  assign in_off    = addr_in[OFF_W-1:0];
  assign in_idx    = addr_in[OFF_W +: IDX_W];
  assign in_tag    = addr_in[AW-1 -: TAG_W];
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign look_hit  = valid_bits[idx_r] && (tag_rdata == tag_r);
  assign slot_free = !rsp_valid || rsp_ready;
  assign fill_last = (state == ST_FILL) && cnt[OFF_W] && rd_valid;

  always_comb begin
    data_we    = 1'b0;
    data_waddr = {idx_r, off_r};
    data_wdata = wdata_r;
    data_raddr = (state == ST_IDLE) ? {in_idx, in_off} : {idx_r, cnt[OFF_W-1:0]};
    if (state == ST_LOOK && look_hit && mode_r == dmwc_pkg::MODE_WRITE) begin
      data_we = 1'b1;
    end
    if (state == ST_FILL && rd_valid) begin
      data_we    = 1'b1;
      data_waddr = {idx_r, rd_off};
      if (!(mode_r == dmwc_pkg::MODE_WRITE && rd_off == off_r)) begin
        data_wdata = back_rdata;
      end
    end
  end

  always_comb begin
    back_we    = 1'b0;
    back_waddr = {old_tag, idx_r, rd_off};
    back_wdata = data_rdata;
    back_raddr = {tag_r, idx_r, cnt[OFF_W-1:0]};
    if (state == ST_CLEAR) begin
      back_we    = 1'b1;
      back_waddr = clr_addr;
      back_wdata = '0;
    end else if (state == ST_WB && rd_valid) begin
      back_we = 1'b1;
    end
  end

  always_comb begin
    push                     = 1'b0;
    push_item.read_data      = res_data;
    push_item.line_was_dirty = res_dirty;
    push_item.hit            = res_hit;
    if (state == ST_LOOK && look_hit && mode_r == dmwc_pkg::MODE_READ && slot_free) begin
      push                     = 1'b1;
      push_item.read_data      = data_rdata;
      push_item.line_was_dirty = dirty_bits[idx_r];
      push_item.hit            = 1'b1;
    end else if (state == ST_DONE && slot_free) begin
      push = 1'b1;
    end
  end

  dmwc_ram #(.WIDTH(BW), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  dmwc_ram #(.WIDTH(TAG_W), .DEPTH(LINE_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (fill_last),
    .waddr (idx_r),
    .wdata (tag_r),
    .raddr (in_idx),
    .rdata (tag_rdata)
  );

  dmwc_ram #(.WIDTH(BW), .DEPTH(BACK_DEPTH)) u_back_ram (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .raddr (back_raddr),
    .rdata (back_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      valid_bits <= '0;
      dirty_bits <= '0;
      cnt        <= '0;
      rd_valid   <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {AW{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            mode_r  <= req.mode;
            off_r   <= in_off;
            idx_r   <= in_idx;
            tag_r   <= in_tag;
            wdata_r <= req.write_data;
            state   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (look_hit) begin
            if (mode_r == dmwc_pkg::MODE_WRITE) begin
              dirty_bits[idx_r] <= 1'b1;
              state             <= ST_IDLE;
            end else if (slot_free) begin
              state <= ST_IDLE;
            end else begin
              res_data  <= data_rdata;
              res_dirty <= dirty_bits[idx_r];
              res_hit   <= 1'b1;
              state     <= ST_DONE;
            end
          end else begin
            old_tag   <= tag_rdata;
            res_dirty <= dirty_bits[idx_r];
            res_hit   <= 1'b0;
            cnt       <= '0;
            rd_valid  <= 1'b0;
            state     <= (valid_bits[idx_r] && dirty_bits[idx_r]) ? ST_WB : ST_FILL;
          end
        end
        ST_WB, ST_FILL: begin
          if (state == ST_FILL && rd_valid && rd_off == off_r) begin
            res_data <= back_rdata;
          end
          if (!cnt[OFF_W]) begin
            cnt      <= cnt + 1'b1;
            rd_valid <= 1'b1;
            rd_off   <= cnt[OFF_W-1:0];
          end else if (rd_valid) begin
            cnt      <= '0;
            rd_valid <= 1'b0;
            if (state == ST_WB) begin
              state <= ST_FILL;
            end else begin
              valid_bits[idx_r] <= 1'b1;
              dirty_bits[idx_r] <= (mode_r == dmwc_pkg::MODE_WRITE);
              state <= (mode_r == dmwc_pkg::MODE_WRITE) ? ST_IDLE : ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/dmwc_checker.sv */
`include "direct_mapped_writeback_cache_defines.svh"

module dmwc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input dmwc_pkg::rsp_t rsp
);

  // A stalled result stays offered and unchanged.
  `DMWC_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

  // The block works on one item at a time, so it never takes two in a row.
  `DMWC_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready)

  // Reset starts the clearing sweep with no item taken and no result shown.
  `DMWC_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !req_ready && !rsp_valid)

endmodule

bind direct_mapped_writeback_cache dmwc_checker u_dmwc_checker (.*);
